// ===== src/plsr_pkg.sv =====
// ----------------------------------------------------------------------------
// plsr_pkg: shared types and codes for the load shed and restore controller.
// Holds request function codes, result kind codes and register indexes.
// ----------------------------------------------------------------------------
package plsr_pkg;

  localparam logic [2:0] FN_WRITE   = 3'd0;
  localparam logic [2:0] FN_SHED    = 3'd1;
  localparam logic [2:0] FN_RESTORE = 3'd2;
  localparam logic [2:0] FN_MANUAL  = 3'd3;
  localparam logic [2:0] FN_CHECK   = 3'd4;

  localparam logic [3:0] K_WRITE = 4'd0;
  localparam logic [3:0] K_AUTO  = 4'd1;
  localparam logic [3:0] K_OVER  = 4'd2;
  localparam logic [3:0] K_REST  = 4'd3;
  localparam logic [3:0] K_MAN   = 4'd4;
  localparam logic [3:0] K_OFF   = 4'd5;
  localparam logic [3:0] K_LOWPF = 4'd6;
  localparam logic [3:0] K_DONE  = 4'd7;
  localparam logic [3:0] K_BAD   = 4'd8;

  localparam logic [1:0] REG_NODE_COUNT = 2'd0;
  localparam logic [1:0] REG_PF_MIN     = 2'd1;
  localparam logic [1:0] REG_SHED_TOL   = 2'd2;

  localparam logic [23:0] VALUE_MAX = 24'hFFFFFF;

  // One table entry as stored in memory.
  typedef struct packed {
    logic [1:0]  prio;
    logic [23:0] power;
    logic        on;
    logic [10:0] pf;
  } node_t;

endpackage

// ===== src/priority_load_shed_restore.sv =====
// ----------------------------------------------------------------------------
// priority_load_shed_restore: prioritized load shedding and restoration.
//
// Requests arrive on the in_ channel (valid/stall) and produce one or more
// results on the out_ channel (valid/stall); the final result of a request
// has out_last set. Configuration registers are written over the cfg_
// channel (valid/ready); cfg_ready is always high. The user must write them
// only while the block is idle; the block itself does not enforce this.
// The node table lives in a single synchronous memory of NODES entries. A
// scan addresses each entry in use, then evaluates its read data. A write,
// a bad index or an unknown function gives its result the cycle after
// acceptance; a manual cut gives its result once the entry has been read.
// A check scans the entries in use once before its done result, a restore
// once for each of priorities 1, 2 and 3. An automatic shed cut takes up to
// three scan passes, then reads the chosen entry again and writes it back.
// The block works on one request at a time; in_stall is high from
// acceptance until the final result has been taken. Reset idles the
// sequencer, clears the output and entry valid bits and loads the
// configuration defaults; entries never written read as zero. A stalled
// receiver holds the output register and the sequencer waits for it to empty.
// ----------------------------------------------------------------------------
module priority_load_shed_restore import plsr_pkg::*; #(
  parameter int NODES = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_func,
  input  logic [3:0]         in_node_index,
  input  logic [1:0]         in_node_priority,
  input  logic [23:0]        in_node_power_w,
  input  logic               in_node_on,
  input  logic [10:0]        in_node_power_factor,
  input  logic [23:0]        in_amount_w,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [3:0]         out_kind,
  output logic [3:0]         out_entry,
  output logic signed [24:0] out_value,
  output logic [4:0]         out_switched_count,
  output logic               out_last,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [10:0]        cfg_data
);

  localparam int AW = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int CW = $clog2(NODES + 1);

  // Sequencer states.
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_READ  = 3'd1; // address presented
  localparam logic [2:0] S_EVAL  = 3'd2; // read data available
  localparam logic [2:0] S_EMIT  = 3'd3; // waiting for output register
  localparam logic [2:0] S_DONE  = 3'd4; // final result
  localparam logic [2:0] S_CUT   = 3'd5; // no shed candidate left, overload
  localparam logic [2:0] S_CUTRD = 3'd6;

  assign cfg_ready = 1'b1;

  // Configuration.
  logic [4:0]  node_count_r;
  logic [10:0] pf_min_r;
  logic [9:0]  tol_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= '0;
      pf_min_r     <= 11'd870;
      tol_r        <= 10'd1;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_NODE_COUNT: node_count_r <= cfg_data[4:0];
        REG_PF_MIN:     pf_min_r     <= cfg_data;
        REG_SHED_TOL:   tol_r        <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  logic [CW-1:0] n_used;
  assign n_used = ({27'd0, node_count_r} < NODES) ? CW'(node_count_r) : CW'(NODES);

  // Table memory with valid bits.
  node_t            mem [NODES];
  logic [NODES-1:0] vld_r;
  logic             we;
  logic [AW-1:0]    waddr, raddr;
  node_t            wdata, rdata_raw, rd;
  logic [AW-1:0]    raddr_q;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_raw <= mem[raddr];
    raddr_q   <= raddr;
  end
  assign rd = vld_r[raddr_q] ? rdata_raw : '0;

  // Control.
  logic [2:0]         state_r, state_nxt;
  logic [2:0]         func_r;
  logic [3:0]         idx_r;
  logic signed [25:0] amt_r, amt_nxt;    // deficit or margin
  logic [24:0]        total_r, total_nxt;
  logic [CW-1:0]      i_r, i_nxt;
  logic [1:0]         prio_r, prio_nxt;
  logic [4:0]         cnt_r, cnt_nxt;
  logic               cover_r, cover_nxt; // pass for covering candidates
  logic               best_v_r, best_v_nxt;
  logic [AW-1:0]      best_i_r, best_i_nxt;
  logic [23:0]        best_p_r, best_p_nxt;
  logic               found_r, found_nxt; // any active entry of priority

  // Output register.
  logic               ov_r;
  logic [3:0]         ok_r, ok_nxt;
  logic [3:0]         oe_r, oe_nxt;
  logic signed [24:0] oval_r, oval_nxt;
  logic [4:0]         oc_r, oc_nxt;
  logic               ol_r, ol_nxt;
  logic               emit;

  assign out_valid          = ov_r;
  assign out_kind           = ok_r;
  assign out_entry          = oe_r;
  assign out_value          = oval_r;
  assign out_switched_count = oc_r;
  assign out_last           = ol_r;

  logic obuf_free;
  assign obuf_free = !ov_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE) || ov_r;

  logic accept;
  assign accept = in_valid && !in_stall;

  // The incoming deficit is above the tolerance, so shedding has work to do.
  logic shed_go;
  assign shed_go = in_amount_w > {14'd0, tol_r};

  always_comb begin
    state_nxt  = state_r;
    amt_nxt    = amt_r;
    total_nxt  = total_r;
    i_nxt      = i_r;
    prio_nxt   = prio_r;
    cnt_nxt    = cnt_r;
    cover_nxt  = cover_r;
    best_v_nxt = best_v_r;
    best_i_nxt = best_i_r;
    best_p_nxt = best_p_r;
    found_nxt  = found_r;
    we         = 1'b0;
    waddr      = i_r[AW-1:0];
    wdata      = rd;
    raddr      = i_r[AW-1:0];
    emit       = 1'b0;
    ok_nxt     = K_DONE;
    oe_nxt     = '0;
    oval_nxt   = '0;
    oc_nxt     = '0;
    ol_nxt     = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          amt_nxt   = $signed({2'b0, in_amount_w});
          total_nxt = '0;
          cnt_nxt   = '0;
          i_nxt     = '0;
          cover_nxt = 1'b1;
          best_v_nxt = 1'b0;
          found_nxt = 1'b0;
          case (in_func)
            FN_WRITE: begin
              if ({28'd0, in_node_index} >= NODES) begin
                emit = 1'b1; ok_nxt = K_BAD; oe_nxt = in_node_index; ol_nxt = 1'b1;
              end else begin
                we    = 1'b1;
                waddr = in_node_index[AW-1:0];
                wdata = '{prio: in_node_priority, power: in_node_power_w,
                          on: in_node_on, pf: in_node_power_factor};
                emit = 1'b1; ok_nxt = K_WRITE; oe_nxt = in_node_index;
                oval_nxt = $signed({1'b0, in_node_power_w}); ol_nxt = 1'b1;
              end
            end
            FN_MANUAL: begin
              if ({28'd0, in_node_index} >= {{(32-CW){1'b0}}, n_used}) begin
                emit = 1'b1; ok_nxt = K_BAD; oe_nxt = in_node_index; ol_nxt = 1'b1;
              end else begin
                i_nxt     = CW'(in_node_index);
                state_nxt = S_READ;
              end
            end
            FN_SHED: begin
              prio_nxt = 2'd3;
              if (!shed_go) state_nxt = S_DONE;
              else if (n_used == '0) state_nxt = S_CUT;
              else state_nxt = S_READ;
            end
            FN_RESTORE: begin
              prio_nxt  = 2'd1;
              state_nxt = (n_used == '0) ? S_DONE : S_READ;
            end
            FN_CHECK: state_nxt = (n_used == '0) ? S_DONE : S_READ;
            default: begin
              emit = 1'b1; ok_nxt = K_BAD; ol_nxt = 1'b1;
            end
          endcase
        end
      end

      S_READ: state_nxt = S_EVAL;

      S_EVAL: begin
        case (func_r)
          FN_MANUAL: begin
            if (obuf_free) begin
              emit = 1'b1; oe_nxt = idx_r; ol_nxt = 1'b1;
              oval_nxt = $signed({1'b0, rd.power});
              if (!rd.on) ok_nxt = K_OFF;
              else begin
                ok_nxt = K_MAN; oc_nxt = 5'd1;
                we = 1'b1; wdata = rd; wdata.on = 1'b0;
              end
              state_nxt = S_IDLE;
            end
          end
          FN_CHECK: begin
            if (rd.on && rd.pf < pf_min_r) begin
              if (obuf_free) begin
                emit = 1'b1; ok_nxt = K_LOWPF; oe_nxt = 4'(i_r[AW-1:0]);
                oval_nxt = $signed({14'd0, rd.pf});
                cnt_nxt = cnt_r + 5'd1;
              end
            end
            if (!(rd.on && rd.pf < pf_min_r) || obuf_free) begin
              if (rd.on) total_nxt = (total_r + {1'b0, rd.power} > {1'b0, VALUE_MAX}) ?
                                     {1'b0, VALUE_MAX} : total_r + {1'b0, rd.power};
              i_nxt = i_r + 1'b1;
              state_nxt = (i_r + 1'b1 == n_used) ? S_DONE : S_READ;
            end
          end
          FN_RESTORE: begin
            if (!rd.on && rd.prio == prio_r && amt_r >= $signed({2'b0, rd.power})) begin
              if (obuf_free) begin
                emit = 1'b1; ok_nxt = K_REST; oe_nxt = 4'(i_r[AW-1:0]);
                oval_nxt = $signed({1'b0, rd.power});
                cnt_nxt = cnt_r + 5'd1;
                amt_nxt = amt_r - $signed({2'b0, rd.power});
                we = 1'b1; wdata = rd; wdata.on = 1'b1;
              end
            end
            if (!(!rd.on && rd.prio == prio_r && amt_r >= $signed({2'b0, rd.power}))
                || obuf_free) begin
              if (i_r + 1'b1 == n_used) begin
                i_nxt = '0;
                if (prio_r == 2'd3) state_nxt = S_DONE;
                else begin prio_nxt = prio_r + 2'd1; state_nxt = S_READ; end
              end else begin
                i_nxt = i_r + 1'b1; state_nxt = S_READ;
              end
            end
          end
          default: begin // shed scan
            if (rd.prio == prio_r && rd.on) begin
              found_nxt = 1'b1;
              if (cover_r) begin
                if ($signed({2'b0, rd.power}) >= amt_r &&
                    (!best_v_r || rd.power < best_p_r)) begin
                  best_v_nxt = 1'b1; best_i_nxt = i_r[AW-1:0]; best_p_nxt = rd.power;
                end
              end else if (!best_v_r || rd.power > best_p_r) begin
                best_v_nxt = 1'b1; best_i_nxt = i_r[AW-1:0]; best_p_nxt = rd.power;
              end
            end
            if (i_r + 1'b1 != n_used) begin
              i_nxt = i_r + 1'b1; state_nxt = S_READ;
            end else begin
              i_nxt = '0;
              state_nxt = S_READ;
              if (best_v_nxt) state_nxt = S_CUTRD;
              else if (cover_r && found_nxt) cover_nxt = 1'b0;
              else if (prio_r == 2'd3) begin
                prio_nxt = 2'd2; cover_nxt = 1'b1; found_nxt = 1'b0;
              end else state_nxt = S_CUT;
            end
          end
        endcase
      end

      S_CUTRD: begin
        raddr = best_i_r;
        state_nxt = S_EMIT;
      end

      S_EMIT: begin
        // rd holds the chosen entry; keep it addressed while the output waits.
        raddr = best_i_r;
        if (obuf_free) begin
          emit = 1'b1; ok_nxt = K_AUTO; oe_nxt = 4'(best_i_r);
          oval_nxt = $signed({1'b0, rd.power});
          we = 1'b1; waddr = best_i_r; wdata = rd; wdata.on = 1'b0;
          cnt_nxt = cnt_r + 5'd1;
          amt_nxt = amt_r - $signed({2'b0, rd.power});
          prio_nxt = 2'd3; cover_nxt = 1'b1; best_v_nxt = 1'b0;
          found_nxt = 1'b0; i_nxt = '0;
          state_nxt = (amt_nxt > $signed({16'd0, tol_r}) && n_used != '0) ?
                      S_READ : S_DONE;
          if (amt_nxt > $signed({16'd0, tol_r}) && n_used == '0) state_nxt = S_CUT;
        end
      end

      S_CUT: begin
        // No candidate left: overload.
        if (obuf_free) begin
          emit = 1'b1; ok_nxt = K_OVER; oval_nxt = amt_r[24:0];
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        if (obuf_free) begin
          emit = 1'b1; ok_nxt = K_DONE; oc_nxt = cnt_r; ol_nxt = 1'b1;
          oval_nxt = (func_r == FN_CHECK) ? $signed(total_r) : amt_r[24:0];
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
      vld_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (emit) ov_r <= 1'b1;
      else if (!out_stall) ov_r <= 1'b0;
      if (we) vld_r[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      func_r <= in_func;
      idx_r  <= in_node_index;
    end
    amt_r    <= amt_nxt;
    total_r  <= total_nxt;
    i_r      <= i_nxt;
    prio_r   <= prio_nxt;
    cnt_r    <= cnt_nxt;
    cover_r  <= cover_nxt;
    best_v_r <= best_v_nxt;
    best_i_r <= best_i_nxt;
    best_p_r <= best_p_nxt;
    found_r  <= found_nxt;
    if (emit) begin
      ok_r   <= ok_nxt;
      oe_r   <= oe_nxt;
      oval_r <= oval_nxt;
      oc_r   <= oc_nxt;
      ol_r   <= ol_nxt;
    end
  end

endmodule
